### design/ssu_pkg.sv
// package: signature table, constants and shared types of the signature scanner
`default_nettype none
package ssu_pkg;

    localparam int CNT_W      = 27;
    localparam int TS_W       = 16;
    localparam int IDX_W      = 6;
    localparam int SCORE_W    = 7;
    localparam int SIG_BYTES  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int DEF_PATTERNS = 23;
    localparam int DEF_MAX_PATTERN_LEN = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_FILE_RESET = 27'd104857600;
    localparam logic [TS_W-1:0]  TEXT_SAMPLE_RESET = 16'd4096;

    localparam logic REG_MAX_FILE    = 1'b0;
    localparam logic REG_TEXT_SAMPLE = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ELF   = 2'd1;
    localparam logic [1:0] KIND_MACHO = 2'd2;
    localparam logic [1:0] KIND_PE    = 2'd3;

    typedef struct packed {
        logic [6:0]           len;
        logic [SCORE_W-1:0]   score;
        logic                 crit;
        logic [8*SIG_BYTES-1:0] seq;
    } sig_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       suppress;
    } file_info_t;

    function automatic sig_t sig_entry(input logic [IDX_W-1:0] idx);
        sig_t s;
        s = '0;
        unique case (idx)
            6'd0:  s = '{7'd16, 7'd80, 1'b1, 128'h90909090909090909090909090909090};
            6'd1:  s = '{7'd16, 7'd80, 1'b1, 128'h90909090909090909090909090909090};
            6'd2:  s = '{7'd16, 7'd75, 1'b1, 128'h0000a0e10000a0e10000a0e10000a0e1};
            6'd3:  s = '{7'd2,  7'd90, 1'b1, {16'hcd80, 112'h0}};
            6'd4:  s = '{7'd2,  7'd90, 1'b1, {16'h0f05, 112'h0}};
            6'd5:  s = '{7'd8,  7'd95, 1'b1, {64'h2f62696e2f736800, 64'h0}};
            6'd6:  s = '{7'd3,  7'd85, 1'b1, {24'h736800, 104'h0}};
            6'd7:  s = '{7'd6,  7'd85, 1'b1, {48'hd9eed97424f4, 80'h0}};
            6'd8:  s = '{7'd5,  7'd80, 1'b1, {40'he800000000, 88'h0}};
            6'd9:  s = '{7'd3,  7'd80, 1'b1, {24'h488d1d, 104'h0}};
            6'd10: s = '{7'd8,  7'd95, 1'b1, {64'h6a6658996a015b52, 64'h0}};
            6'd11: s = '{7'd10, 7'd95, 1'b1, {80'h6a2958996a025f6a015e, 48'h0}};
            6'd12: s = '{7'd8,  7'd95, 1'b1, {64'h31c031db31c9b066, 64'h0}};
            6'd13: s = '{7'd9,  7'd92, 1'b1, {72'h2f6465762f7463702f, 56'h0}};
            6'd14: s = '{7'd3,  7'd90, 1'b1, {24'hfce882, 104'h0}};
            6'd15: s = '{7'd8,  7'd90, 1'b1, {64'hfc4883e4f0e8c000, 64'h0}};
            6'd16: s = '{7'd5,  7'd85, 1'b1, {40'h6a4358cd80, 88'h0}};
            6'd17: s = '{7'd2,  7'd90, 1'b1, {16'h94c3, 112'h0}};
            6'd18: s = '{7'd16, 7'd75, 1'b0, 128'h0c0c0c0c0c0c0c0c0c0c0c0c0c0c0c0c};
            6'd19: s = '{7'd2,  7'd85, 1'b1, {16'hffe4, 112'h0}};
            6'd20: s = '{7'd2,  7'd85, 1'b1, {16'hffd4, 112'h0}};
            6'd21: s = '{7'd7,  7'd80, 1'b0, {56'hd9e1d97424f458, 72'h0}};
            6'd22: s = '{7'd7,  7'd85, 1'b1, {56'hd9eed97424f45a, 72'h0}};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### design/ssu_front.sv
// front: byte window match, header class, text count and file summary
`default_nettype none
module ssu_front #(
    parameter int PATTERNS        = ssu_pkg::DEF_PATTERNS,
    parameter int MAX_PATTERN_LEN = ssu_pkg::DEF_MAX_PATTERN_LEN
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_index,
    input  wire logic [ssu_pkg::CNT_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        last_byte,
    output logic                             sum_valid,
    input  wire logic                        sum_ready,
    output logic [PATTERNS-1:0]              sum_flags,
    output logic [PATTERNS*ssu_pkg::CNT_W-1:0] sum_offs,
    output ssu_pkg::file_info_t              sum_info
);
    localparam int CW = ssu_pkg::CNT_W;
    localparam int WD = MAX_PATTERN_LEN - 1;

    logic [CW-1:0]              max_file_reg;
    logic [ssu_pkg::TS_W-1:0]   text_sample_reg;
    logic [7:0]                 win_reg [WD];
    logic [CW-1:0]              count_reg, count_next;
    logic [31:0]                header_reg, header_next;
    logic [ssu_pkg::TS_W-1:0]   nonprint_reg, nonprint_next;
    logic [PATTERNS-1:0]        flags_reg, hit;
    logic [CW-1:0]              offs_reg [PATTERNS];
    logic [CW-1:0]              offs_new [PATTERNS];
    logic                       oversize_reg, oversize_next;
    logic [7:0]                 cur [MAX_PATTERN_LEN];
    logic                       accept;
    logic [1:0]                 kind;
    logic [ssu_pkg::TS_W-1:0]   sample;
    logic [20:0]                need;
    logic                       text_low;

    function automatic logic [1:0] classify(input logic [CW-1:0] size, input logic [31:0] h);
        logic [7:0] h0, h1, h3;
        h0 = h[31:24];
        h1 = h[23:16];
        h3 = h[7:0];
        if (size < CW'(4))
            return ssu_pkg::KIND_NONE;
        if (h == 32'h7f454c46)
            return ssu_pkg::KIND_ELF;
        if ((h[31:8] == 24'hfeedfa && (h3 == 8'hce || h3 == 8'hcf)) ||
            h == 32'hcefaedfe || h == 32'hcffaedfe || h == 32'hcafebabe)
            return ssu_pkg::KIND_MACHO;
        if (h0 == 8'h4d && h1 == 8'h5a)
            return ssu_pkg::KIND_PE;
        return ssu_pkg::KIND_NONE;
    endfunction

    assign in_ready  = sum_ready;
    assign accept    = in_valid && in_ready;
    assign sum_valid = accept && last_byte;

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            if (k == MAX_PATTERN_LEN - 1)
                cur[k] = data_byte;
            else
                cur[k] = win_reg[MAX_PATTERN_LEN - 2 - k];
        end
    end

    for (genvar p = 0; p < PATTERNS; p++)
    begin : g_sig
        localparam ssu_pkg::sig_t SIG = ssu_pkg::sig_entry(ssu_pkg::IDX_W'(p));
        localparam int LEN = int'(SIG.len);
        if (LEN > 0 && LEN <= MAX_PATTERN_LEN)
        begin : g_cmp
            always_comb
            begin
                hit[p] = !flags_reg[p] && (count_reg >= CW'(LEN - 1));
                for (int i = 0; i < LEN; i++)
                begin
                    if (cur[MAX_PATTERN_LEN - LEN + i] != SIG.seq[8*ssu_pkg::SIG_BYTES-1-8*i -: 8])
                        hit[p] = 1'b0;
                end
            end
            assign offs_new[p] = count_reg + CW'(1) - CW'(LEN);
        end
        else
        begin : g_none
            assign hit[p]      = 1'b0;
            assign offs_new[p] = '0;
        end

        always_ff @(posedge clk)
        begin
            if (accept && hit[p])
                offs_reg[p] <= offs_new[p];
        end

        assign sum_offs[p*CW +: CW] = hit[p] ? offs_new[p] : offs_reg[p];
    end

    always_comb
    begin
        oversize_next = oversize_reg || (count_reg == ssu_pkg::CNT_MAX);
        count_next    = (count_reg == ssu_pkg::CNT_MAX) ? count_reg : count_reg + CW'(1);
        header_next   = header_reg;
        if (count_reg < CW'(4))
            header_next[31 - 8*count_reg[1:0] -: 8] = data_byte;
        nonprint_next = nonprint_reg;
        if (count_reg < CW'(text_sample_reg) &&
            (data_byte < 8'h09 || (data_byte > 8'h0d && data_byte < 8'h20)))
            nonprint_next = nonprint_reg + ssu_pkg::TS_W'(1);
        kind     = classify(count_next, header_next);
        sample   = (count_next < CW'(text_sample_reg)) ? count_next[ssu_pkg::TS_W-1:0]
                                                      : text_sample_reg;
        need     = ({5'd0, nonprint_next} + 21'd1) * 21'd10;
        text_low = (kind == ssu_pkg::KIND_NONE) && (need <= 21'(sample));
        sum_flags         = flags_reg | hit;
        sum_info.kind     = kind;
        sum_info.suppress = oversize_next || (count_next > max_file_reg) || text_low;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_file_reg    <= ssu_pkg::MAX_FILE_RESET;
            text_sample_reg <= ssu_pkg::TEXT_SAMPLE_RESET;
            for (int k = 0; k < WD; k++)
                win_reg[k] <= '0;
            count_reg    <= '0;
            header_reg   <= '0;
            nonprint_reg <= '0;
            flags_reg    <= '0;
            oversize_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == ssu_pkg::REG_MAX_FILE)
                    max_file_reg <= cfg_data;
                else
                    text_sample_reg <= cfg_data[ssu_pkg::TS_W-1:0];
            end
            if (accept)
            begin
                if (last_byte)
                begin
                    for (int k = 0; k < WD; k++)
                        win_reg[k] <= '0;
                    count_reg    <= '0;
                    header_reg   <= '0;
                    nonprint_reg <= '0;
                    flags_reg    <= '0;
                    oversize_reg <= 1'b0;
                end
                else
                begin
                    for (int k = WD - 1; k > 0; k--)
                        win_reg[k] <= win_reg[k-1];
                    win_reg[0]   <= data_byte;
                    count_reg    <= count_next;
                    header_reg   <= header_next;
                    nonprint_reg <= nonprint_next;
                    flags_reg    <= flags_reg | hit;
                    oversize_reg <= oversize_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

### design/ssu_fifo.sv
// small queue of file summaries between front and back
`default_nettype none
module ssu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ssu_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  not_full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    cnt_reg;

    assign not_full  = cnt_reg != CW'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rdata     = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && not_full)
            mem[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && not_full)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (pop && not_empty)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            cnt_reg <= cnt_reg + CW'(push && not_full) - CW'(pop && not_empty);
        end
    end

endmodule
`default_nettype wire

### design/ssu_back.sv
// back: walks the found flags of one file and issues its result beats
`default_nettype none
module ssu_back #(
    parameter int PATTERNS = ssu_pkg::DEF_PATTERNS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sum_valid,
    output logic                               sum_ready,
    input  wire logic [PATTERNS-1:0]           sum_flags,
    input  wire logic [PATTERNS*ssu_pkg::CNT_W-1:0] sum_offs,
    input  wire ssu_pkg::file_info_t           sum_info,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               matched,
    output logic [ssu_pkg::IDX_W-1:0]          pattern_index,
    output logic [ssu_pkg::CNT_W-1:0]          match_offset,
    output logic [ssu_pkg::SCORE_W-1:0]        score,
    output logic                               severity,
    output logic [1:0]                         file_kind,
    output logic                               last_result
);
    localparam int CW = ssu_pkg::CNT_W;
    localparam int IW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;

    logic                 busy_reg;
    logic [PATTERNS-1:0]  flags_reg, flags_left;
    ssu_pkg::file_info_t  info_reg;
    logic [CW-1:0]        offs_reg [PATTERNS];
    logic                 out_valid_reg;
    logic                 can_load, emit, none;
    logic [IW-1:0]        idx;
    ssu_pkg::sig_t        sig;

    assign can_load  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && can_load;
    assign sum_ready = !busy_reg;
    assign out_valid = out_valid_reg;
    assign none      = info_reg.suppress || (flags_reg == '0);

    always_comb
    begin
        idx = '0;
        for (int i = PATTERNS - 1; i >= 0; i--)
        begin
            if (flags_reg[i])
                idx = IW'(i);
        end
        flags_left      = flags_reg;
        flags_left[idx] = 1'b0;
        sig             = ssu_pkg::sig_entry(ssu_pkg::IDX_W'(idx));
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && sum_valid)
        begin
            for (int p = 0; p < PATTERNS; p++)
                offs_reg[p] <= sum_offs[p*CW +: CW];
            info_reg <= sum_info;
        end
        if (emit)
        begin
            file_kind <= info_reg.kind;
            if (none)
            begin
                matched       <= 1'b0;
                pattern_index <= '0;
                match_offset  <= '0;
                score         <= '0;
                severity      <= 1'b0;
                last_result   <= 1'b1;
            end
            else
            begin
                matched       <= 1'b1;
                pattern_index <= ssu_pkg::IDX_W'(idx);
                match_offset  <= offs_reg[idx];
                score         <= sig.score;
                severity      <= sig.crit;
                last_result   <= flags_left == '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg && sum_valid)
            begin
                busy_reg  <= 1'b1;
                flags_reg <= sum_flags;
            end
            else if (emit)
            begin
                flags_reg <= flags_left;
                if (none || flags_left == '0)
                    busy_reg <= 1'b0;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### design/shellcode_signature_scanner_unit.sv
// signature scanner top: front matcher, summary queue and result back end
// one byte accepted per cycle while the summary queue has room; all signatures compare in parallel on the live window
// every input byte waits while the two-entry summary queue is full
// the back end takes a summary while idle, then issues its result beats as the output accepts them
// the last byte's summary is queued, taken by an idle back end, then registered as the first result beat
// reset clears all control state and the per-file counters, window and flags; configuration resets to its defaults
`default_nettype none
module shellcode_signature_scanner_unit #(
    parameter int PATTERNS        = ssu_pkg::DEF_PATTERNS,
    parameter int MAX_PATTERN_LEN = ssu_pkg::DEF_MAX_PATTERN_LEN
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [ssu_pkg::CNT_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        last_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             matched,
    output logic [ssu_pkg::IDX_W-1:0]        pattern_index,
    output logic [ssu_pkg::CNT_W-1:0]        match_offset,
    output logic [ssu_pkg::SCORE_W-1:0]      score,
    output logic                             severity,
    output logic [1:0]                       file_kind,
    output logic                             last_result
);
    localparam int OW    = PATTERNS * ssu_pkg::CNT_W;
    localparam int SUM_W = PATTERNS + OW + $bits(ssu_pkg::file_info_t);

    logic                     f_valid, q_not_full, q_not_empty, b_ready;
    logic [PATTERNS-1:0]      f_flags, q_flags;
    logic [OW-1:0]            f_offs, q_offs;
    ssu_pkg::file_info_t      f_info, q_info;
    logic [SUM_W-1:0]         q_rdata;

    assign cfg_ready = 1'b1;

    ssu_front #(
        .PATTERNS        (PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .sum_valid (f_valid),
        .sum_ready (q_not_full),
        .sum_flags (f_flags),
        .sum_offs  (f_offs),
        .sum_info  (f_info)
    );

    ssu_fifo #(
        .WIDTH (SUM_W),
        .DEPTH (ssu_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .wdata     ({f_flags, f_offs, f_info}),
        .not_full  (q_not_full),
        .pop       (b_ready),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    assign {q_flags, q_offs, q_info} = q_rdata;

    ssu_back #(
        .PATTERNS (PATTERNS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .sum_valid     (q_not_empty),
        .sum_ready     (b_ready),
        .sum_flags     (q_flags),
        .sum_offs      (q_offs),
        .sum_info      (q_info),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matched       (matched),
        .pattern_index (pattern_index),
        .match_offset  (match_offset),
        .score         (score),
        .severity      (severity),
        .file_kind     (file_kind),
        .last_result   (last_result)
    );

    a_nomatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> last_result && pattern_index == '0 &&
            match_offset == '0 && score == '0 && !severity)
        else $error("no-match beat carries stray fields");

    a_match_scored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> score != '0)
        else $error("matched beat without score");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && matched && !last_result ##1 out_valid |->
            matched && pattern_index > $past(pattern_index))
        else $error("result beats out of table order");

endmodule
`default_nettype wire

### sim/tb_top.sv
// testbench for the signature scanner: byte stream driver, result monitor and predictor
`default_nettype none
module tb_top;

    localparam int NSIG = 23;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [7:0] b;
        logic       l;
    } file_beat_t;

    typedef struct {
        logic                        m;
        logic [ssu_pkg::IDX_W-1:0]   idx;
        logic [ssu_pkg::CNT_W-1:0]   off;
        logic [ssu_pkg::SCORE_W-1:0] sc;
        logic                        sev;
        logic [1:0]                  kind;
        logic                        lr;
    } finding_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = ssu_pkg::REG_MAX_FILE;
    logic [ssu_pkg::CNT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] data_byte = '0;
    logic last_byte = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic matched;
    logic [ssu_pkg::IDX_W-1:0] pattern_index;
    logic [ssu_pkg::CNT_W-1:0] match_offset;
    logic [ssu_pkg::SCORE_W-1:0] score;
    logic severity;
    logic [1:0] file_kind;
    logic last_result;

    shellcode_signature_scanner_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready), .matched(matched),
        .pattern_index(pattern_index), .match_offset(match_offset), .score(score),
        .severity(severity), .file_kind(file_kind), .last_result(last_result)
    );

    int sig_len [NSIG] = '{16, 16, 16, 2, 2, 8, 3, 6, 5, 3, 8, 10, 8, 9, 3, 8, 5, 2, 16, 2,
        2, 7, 7};
    int sig_score [NSIG] = '{80, 80, 75, 90, 90, 95, 85, 85, 80, 80, 95, 95, 95, 92, 90, 90,
        85, 90, 75, 85, 85, 80, 85};
    bit sig_crit [NSIG] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 1};
    logic [127:0] sig_seq [NSIG] = '{
        128'h90909090909090909090909090909090,
        128'h90909090909090909090909090909090,
        128'h0000a0e10000a0e10000a0e10000a0e1,
        {16'hcd80, 112'h0},
        {16'h0f05, 112'h0},
        {64'h2f62696e2f736800, 64'h0},
        {24'h736800, 104'h0},
        {48'hd9eed97424f4, 80'h0},
        {40'he800000000, 88'h0},
        {24'h488d1d, 104'h0},
        {64'h6a6658996a015b52, 64'h0},
        {80'h6a2958996a025f6a015e, 48'h0},
        {64'h31c031db31c9b066, 64'h0},
        {72'h2f6465762f7463702f, 56'h0},
        {24'hfce882, 104'h0},
        {64'hfc4883e4f0e8c000, 64'h0},
        {40'h6a4358cd80, 88'h0},
        {16'h94c3, 112'h0},
        128'h0c0c0c0c0c0c0c0c0c0c0c0c0c0c0c0c,
        {16'hffe4, 112'h0},
        {16'hffd4, 112'h0},
        {56'hd9e1d97424f458, 72'h0},
        {56'hd9eed97424f45a, 72'h0}
    };

    // scanner model state
    longint max_file_lim = ssu_pkg::MAX_FILE_RESET;
    longint text_sample_lim = ssu_pkg::TEXT_SAMPLE_RESET;
    logic [7:0] win [15];
    longint byte_cnt = 0;
    logic [31:0] magic = '0;
    logic [15:0] nonprint = '0;
    bit found [NSIG];
    longint first_off [NSIG];
    bit oversize = 0;

    file_beat_t byte_q[$];
    finding_t finding_q[$];
    logic [7:0] fbuf[$];
    int errors = 0;
    bit no_idle = 0;
    bit hold_req = 0;
    int in_gap = 0;
    int out_stall = 0;
    int hold_left = 0;
    bit hold_taken = 0;
    int quiet_cycles = 0;

    function automatic void clear_file();
        for (int i = 0; i < 15; i++) win[i] = '0;
        byte_cnt = 0;
        magic = '0;
        nonprint = '0;
        for (int p = 0; p < NSIG; p++) found[p] = 0;
        oversize = 0;
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic l);
        logic [7:0] cur [16];
        longint pos;
        longint size;
        longint smp;
        int len;
        bit hit;
        bit sup;
        logic [1:0] kind;
        logic [7:0] h0, h1, h2, h3;
        finding_t r;
        int n;
        pos = byte_cnt;
        if (pos >= longint'(ssu_pkg::CNT_MAX)) oversize = 1;
        for (int i = 0; i < 15; i++) cur[14-i] = win[i];
        cur[15] = b;
        for (int p = 0; p < NSIG; p++)
        begin
            len = sig_len[p];
            if (pos + 1 < len || found[p]) continue;
            hit = 1;
            for (int i = 0; i < len; i++)
                if (cur[16-len+i] != sig_seq[p][127-8*i -: 8]) hit = 0;
            if (hit)
            begin
                found[p] = 1;
                first_off[p] = pos + 1 - len;
            end
        end
        if (pos < 4) magic[8*(3-int'(pos)) +: 8] = b;
        if (pos < text_sample_lim && (b < 8'h09 || (b > 8'h0d && b < 8'h20)))
            nonprint = nonprint + 16'd1;
        for (int i = 14; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (pos < longint'(ssu_pkg::CNT_MAX)) byte_cnt = pos + 1;
        if (!l) return;

        size = byte_cnt;
        {h0, h1, h2, h3} = magic;
        kind = ssu_pkg::KIND_NONE;
        if (size >= 4)
        begin
            if (h0 == 8'h7f && h1 == 8'h45 && h2 == 8'h4c && h3 == 8'h46)
                kind = ssu_pkg::KIND_ELF;
            else if ((h0 == 8'hfe && h1 == 8'hed && h2 == 8'hfa && (h3 == 8'hce || h3 == 8'hcf))
                || (h0 == 8'hce && h1 == 8'hfa && h2 == 8'hed && h3 == 8'hfe)
                || (h0 == 8'hcf && h1 == 8'hfa && h2 == 8'hed && h3 == 8'hfe)
                || (h0 == 8'hca && h1 == 8'hfe && h2 == 8'hba && h3 == 8'hbe))
                kind = ssu_pkg::KIND_MACHO;
            else if (h0 == 8'h4d && h1 == 8'h5a) kind = ssu_pkg::KIND_PE;
        end
        sup = oversize || size == 0 || size > max_file_lim;
        if (!sup && kind == ssu_pkg::KIND_NONE)
        begin
            smp = size < text_sample_lim ? size : text_sample_lim;
            if (longint'(nonprint) < smp / 10) sup = 1;
        end
        n = 0;
        if (!sup)
            for (int p = 0; p < NSIG; p++)
                if (found[p])
                begin
                    r = '{1'b1, ssu_pkg::IDX_W'(p), ssu_pkg::CNT_W'(first_off[p]),
                        ssu_pkg::SCORE_W'(sig_score[p]), sig_crit[p], kind, 1'b0};
                    finding_q.insert(finding_q.size(), r);
                    n++;
                end
        if (n == 0)
        begin
            r = '{1'b0, '0, '0, '0, 1'b0, kind, 1'b0};
            finding_q.insert(finding_q.size(), r);
        end
        finding_q[finding_q.size()-1].lr = 1'b1;
        clear_file();
    endfunction

    function automatic void check_field(input string name, input longint e, input longint a);
        if (e != a)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, a);
            errors++;
        end
    endfunction

    initial
    begin
        forever #6 clk = ~clk;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        file_beat_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                scan_byte(data_byte, last_byte);
                in_gap = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0 || byte_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0) in_gap--;
                end
                else
                begin
                    it = byte_q.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= it.b;
                    last_byte <= it.l;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        finding_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (finding_q.size() == 0)
                begin
                    $error("unexpected result beat, pattern_index %0d", pattern_index);
                    errors++;
                end
                else
                begin
                    e = finding_q.pop_front();
                    check_field("matched", e.m, matched);
                    check_field("pattern_index", e.idx, pattern_index);
                    check_field("match_offset", e.off, match_offset);
                    check_field("score", e.sc, score);
                    check_field("severity", e.sev, severity);
                    check_field("file_kind", e.kind, file_kind);
                    check_field("last_result", e.lr, last_result);
                end
                out_stall = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [ssu_pkg::CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ssu_pkg::REG_MAX_FILE) max_file_lim = val;
        else text_sample_lim = val[15:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic send_file();
        for (int i = 0; i < fbuf.size(); i++)
            byte_q.insert(byte_q.size(), '{fbuf[i], i == fbuf.size() - 1});
    endtask

    task automatic rand_file(input int maxlen);
        int len;
        int p;
        int sel;
        len = $urandom_range(1, maxlen);
        fbuf = {};
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: fbuf = '{8'h7f, 8'h45, 8'h4c, 8'h46};
            2: fbuf = '{8'hfe, 8'hed, 8'hfa, $urandom_range(0, 1) ? 8'hce : 8'hcf};
            3: fbuf = '{8'hce, 8'hfa, 8'hed, 8'hfe};
            4: fbuf = '{$urandom_range(0, 1) ? 8'hcf : 8'hca, 8'hfa, 8'hed, 8'hfe};
            5: fbuf = '{8'hca, 8'hfe, 8'hba, 8'hbe};
            6, 7: fbuf = '{8'h4d, 8'h5a};
            default: fbuf = {};
        endcase
        while (fbuf.size() < len)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
            begin
                p = $urandom_range(0, NSIG - 1);
                for (int i = 0; i < sig_len[p]; i++)
                    fbuf.insert(fbuf.size(), sig_seq[p][127-8*i -: 8]);
            end
            else if (sel < 5)
                fbuf.insert(fbuf.size(), $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                    : 8'($urandom_range(14, 31)));
            else
                fbuf.insert(fbuf.size(), 8'($urandom));
        end
        send_file();
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (byte_q.size() != 0 || in_valid || finding_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        clear_file();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed files under reset configuration
        fbuf = '{8'h7f, 8'h45, 8'h4c, 8'h46, 8'hcd, 8'h80};
        send_file();
        fbuf = '{8'h4d, 8'h5a, 8'h0f, 8'h05};
        send_file();
        fbuf = '{8'h00};
        send_file();
        fbuf = '{8'h41, 8'h42, 8'h43, 8'h20, 8'h61, 8'h62, 8'h63, 8'h7e, 8'h41, 8'h42,
            8'h94, 8'hc3};
        send_file();
        fbuf = '{8'hcf, 8'hfa, 8'hed, 8'hfe, 8'hff, 8'he4, 8'hff};
        send_file();
        wait_idle();

        write_reg(ssu_pkg::REG_MAX_FILE, ssu_pkg::MAX_FILE_RESET);
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, ssu_pkg::TEXT_SAMPLE_RESET);
        for (int f = 0; f < 5; f++) rand_file(40);
        wait_idle();

        write_reg(ssu_pkg::REG_MAX_FILE, 27'd5);
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, '0);
        for (int f = 0; f < 5; f++) rand_file(12);
        wait_idle();

        // receiver holds off while short files pile up
        write_reg(ssu_pkg::REG_MAX_FILE, ssu_pkg::CNT_MAX);
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, 27'd65535);
        no_idle <= 1'b1;
        hold_req <= 1'b1;
        for (int f = 0; f < 14; f++) rand_file(3);
        for (int f = 0; f < 2; f++) rand_file(30);
        wait_idle();
        no_idle <= 1'b0;

        write_reg(ssu_pkg::REG_MAX_FILE, '0);
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, ssu_pkg::CNT_W'($urandom));
        for (int f = 0; f < 3; f++) rand_file(10);
        wait_idle();

        write_reg(ssu_pkg::REG_MAX_FILE, 27'd1);
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, 27'd1);
        fbuf = '{8'h90};
        send_file();
        for (int f = 0; f < 3; f++) rand_file(8);
        wait_idle();

        write_reg(ssu_pkg::REG_MAX_FILE, ssu_pkg::CNT_W'($urandom_range(1, 200)));
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, ssu_pkg::CNT_W'($urandom_range(1, 60)));
        for (int f = 0; f < 4; f++) rand_file(40);
        wait_idle();

        write_reg(ssu_pkg::REG_MAX_FILE, ssu_pkg::MAX_FILE_RESET);
        write_reg(ssu_pkg::REG_TEXT_SAMPLE, ssu_pkg::TEXT_SAMPLE_RESET);
        no_idle <= 1'b1;
        rand_file(40);
        wait_idle();
        no_idle <= 1'b0;
        rand_file(40);
        wait_idle();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
design/ssu_pkg.sv
design/ssu_front.sv
design/ssu_fifo.sv
design/ssu_back.sv
design/shellcode_signature_scanner_unit.sv
sim/tb_top.sv
